@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// when cond holds, expr must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed");

`endif

@@ rtl/lru_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU list package
// Field widths, command and status codes, and shared types.
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int LRU_CAPACITY = 16;
	localparam int LRU_KEY_BITS = 16;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// broadcast to every cell
	typedef struct packed {
		logic ins_en; // shift toward older end up to the hit (or everywhere)
		logic era_en; // close the gap from the hit onward
	} ctl_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    victim_key;
		logic [COUNT_W-1:0]  count;
	} resp_t;

endpackage

@@ rtl/lru_cell.sv @@
// ----------------------------------------------------------------------------
// LRU list cell
// One list slot: compares its key, passes hit and victim chains along,
// and loads from a neighbor when the list shifts.
// ----------------------------------------------------------------------------
module lru_cell #(
	parameter int KW = lru_pkg::LRU_KEY_BITS
) (
	input  logic          clk,
	input  lru_pkg::ctl_t ctl,
	input  logic [KW-1:0] search_key,
	input  logic [KW-1:0] left_key,
	input  logic [KW-1:0] right_key,
	input  logic          valid,
	input  logic          last,
	input  logic          hit_before_in,
	input  logic [KW-1:0] vict_in,
	output logic          hit_before_out,
	output logic [KW-1:0] vict_out,
	output logic [KW-1:0] key,
	output logic          hit
);
	import lru_pkg::*;

	logic [KW-1:0] key_q;

	assign key            = key_q;
	assign hit            = valid && (key_q == search_key);
	assign hit_before_out = hit_before_in | hit;
	assign vict_out       = vict_in | (last ? key_q : '0);

	always_ff @(posedge clk) begin
		if (ctl.ins_en && !hit_before_in) begin
			key_q <= left_key;
		end else if (ctl.era_en && (hit_before_in || hit)) begin
			key_q <= right_key;
		end
	end

endmodule

@@ rtl/lru_resp_buf.sv @@
// ----------------------------------------------------------------------------
// LRU response buffer
// Output register plus one skid entry so a new item can be taken while
// a finished result is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_resp_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lru_pkg::resp_t push_data,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output lru_pkg::resp_t out_data
);
	import lru_pkg::*;

	logic  out_valid_q;
	logic  skid_valid_q;
	resp_t out_q;
	resp_t skid_q;
	logic  take;

	assign take      = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	`ASSERT_IMPLIES(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, skid_valid_q, !push)

endmodule

@@ rtl/lru_replacement_list.sv @@
// ----------------------------------------------------------------------------
// LRU replacement list
// Ordered list of distinct keys, most recent first, held in a row of cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   cmd, key
//  result    out        out_valid / out_stall status, victim_key, count
//
// One item per cycle while in_stall is low: all cells compare in parallel
// and the list shifts in the cycle of the transfer; the result is registered
// in the output buffer. The hit chain through the cells sets the cycle time.
// Reset empties the list; no clearing pass is needed.
// in_stall rises only while a result waits in the skid entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_replacement_list #(
	parameter int CAPACITY = lru_pkg::LRU_CAPACITY,
	parameter int KEY_BITS = lru_pkg::LRU_KEY_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lru_pkg::CMD_W-1:0]      cmd,
	input  logic [lru_pkg::KEY_W-1:0]      key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lru_pkg::STATUS_W-1:0]   status,
	output logic [lru_pkg::KEY_W-1:0]      victim_key,
	output logic [lru_pkg::COUNT_W-1:0]    count
);
	import lru_pkg::*;

	localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CEXT  = (CW > COUNT_W) ? CW : COUNT_W;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic          accept;
	logic          buf_full;
	logic [KW-1:0] skey;
	ctl_t          ctl;
	resp_t         resp;
	resp_t         out_data;
	logic          any_hit;
	logic          is_full;

	logic [CAPACITY-1:0]         hits;
	logic [CAPACITY:0]           hit_chain;
	logic [CAPACITY:0][KW-1:0]   vict_chain;
	logic [CAPACITY-1:0][KW-1:0] cell_keys;
	logic [CEXT-1:0]             cnt_ext;

	assign skey     = key[KW-1:0];
	assign accept   = in_valid && !buf_full;
	assign in_stall = buf_full;
	assign any_hit  = hit_chain[CAPACITY];
	assign is_full  = (cnt_q == CW'(CAPACITY));

	assign hit_chain[0]  = 1'b0;
	assign vict_chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KW-1:0] left;
		logic [KW-1:0] right;
		if (i == 0) begin : g_first
			assign left = skey;
		end else begin : g_mid
			assign left = cell_keys[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right = cell_keys[i];
		end else begin : g_inner
			assign right = cell_keys[i+1];
		end
		lru_cell #(.KW(KW)) u_cell (
			.clk            (clk),
			.ctl            (ctl),
			.search_key     (skey),
			.left_key       (left),
			.right_key      (right),
			.valid          (CW'(i) < cnt_q),
			.last           (CW'(i + 1) == cnt_q),
			.hit_before_in  (hit_chain[i]),
			.vict_in        (vict_chain[i]),
			.hit_before_out (hit_chain[i+1]),
			.vict_out       (vict_chain[i+1]),
			.key            (cell_keys[i]),
			.hit            (hits[i])
		);
	end

	always_comb begin
		ctl        = '0;
		cnt_next   = cnt_q;
		resp       = '0;
		resp.status = ST_DONE;
		unique case (cmd)
			CMD_INSERT: begin
				if (any_hit) begin
					ctl.ins_en = accept;
				end else if (is_full) begin
					resp.status = ST_FULL;
				end else begin
					ctl.ins_en = accept;
					cnt_next   = cnt_q + 1'b1;
				end
			end
			CMD_VICTIM: begin
				if (cnt_q == '0) begin
					resp.status = ST_MISS;
				end else begin
					resp.victim_key = KEY_W'(vict_chain[CAPACITY]);
					cnt_next        = cnt_q - 1'b1;
				end
			end
			CMD_ERASE: begin
				if (any_hit) begin
					ctl.era_en = accept;
					cnt_next   = cnt_q - 1'b1;
				end else begin
					resp.status = ST_MISS;
				end
			end
			default: begin
			end
		endcase
		cnt_ext    = CEXT'(cnt_next);
		resp.count = cnt_ext[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	lru_resp_buf u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (resp),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign status     = out_data.status;
	assign victim_key = out_data.victim_key;
	assign count      = out_data.count;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, cnt_q <= CW'(CAPACITY))
	`ASSERT_ALWAYS(a_single_hit, clk, arst_n, $onehot0(hits))
	`ASSERT_IMPLIES(a_stall_has_result, clk, arst_n, in_stall, out_valid)

endmodule

@@ verif/tb_lru_replacement_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU replacement list testbench
// Drives insert, victim, erase and unused commands through the valid/stall
// input channel, keeps its own copy of the recency order, and checks every
// result field against it, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_lru_replacement_list;
	import lru_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;  // unused code, no operation
	localparam int HOLD_OFF_CYCLES = 80;

	// Tracks the recency order and queues the result each command must produce.
	class lru_list_tracker;
		logic [KEY_W-1:0] order_q[$];  // entry 0 is most recent
		resp_t            results_q[$];
		int               mismatches;

		function void note_op(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
			resp_t r;
			int    hit[$];
			r.status = ST_DONE;
			r.victim_key = '0;
			hit = order_q.find_first_index(item) with (item == k);
			case (op)
				CMD_INSERT: begin
					if (hit.size() != 0) begin
						order_q.delete(hit[0]);
						order_q.push_front(k);
					end else if (order_q.size() >= LRU_CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						order_q.push_front(k);
					end
				end
				CMD_VICTIM: begin
					if (order_q.size() == 0)
						r.status = ST_MISS;
					else
						r.victim_key = order_q.pop_back();
				end
				CMD_ERASE: begin
					if (hit.size() != 0)
						order_q.delete(hit[0]);
					else
						r.status = ST_MISS;
				end
				default: ;
			endcase
			r.count = COUNT_W'(order_q.size());
			results_q.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] vk,
				logic [COUNT_W-1:0] cnt);
			resp_t want;
			if (results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none pending: status=%0d victim=%h count=%0d",
						$realtime, st, vk, cnt);
				return;
			end
			want = results_q.pop_front();
			if (st !== want.status || vk !== want.victim_key || cnt !== want.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected status=%0d victim=%h count=%0d, got status=%0d victim=%h count=%0d",
						$realtime, want.status, want.victim_key, want.count, st, vk, cnt);
			end
		endfunction

		function int pending();
			return results_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd = CMD_INSERT;
	logic [KEY_W-1:0]    key = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    victim_key;
	logic [COUNT_W-1:0]  count;

	bit quiet = 1'b0;          // no idling on either side
	bit pressure_req = 1'b0;   // ask the receiver for a long hold-off
	int hold_left = 0;

	lru_list_tracker tracker = new();

	lru_replacement_list uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key        (key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.victim_key (victim_key),
		.count      (count)
	);

	always #6 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (pressure_req) begin
			hold_left = HOLD_OFF_CYCLES;
			pressure_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(status, victim_key, count);
	end

	// Present one command and hold it until the transfer.
	task automatic send_op(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key <= k;
		do @(posedge clk); while (in_stall);
		tracker.note_op(op, k);
	endtask

	// Mostly keys from a small pool so touches, hits and a full list occur;
	// a share of keys spans the whole range.
	task automatic run_mixed(int n, int pool_size, int wide_pct);
		logic [KEY_W-1:0] pool[$];
		logic [CMD_W-1:0] op;
		logic [KEY_W-1:0] k;
		int               roll;
		for (int i = 0; i < pool_size; i++)
			pool.push_back(KEY_W'($urandom_range(0, 65535)));
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				op = CMD_INSERT;
			else if (roll < 72)
				op = CMD_VICTIM;
			else if (roll < 95)
				op = CMD_ERASE;
			else
				op = CMD_NOP;
			if ($urandom_range(0, 99) < wide_pct)
				k = KEY_W'($urandom_range(0, 65535));
			else
				k = pool[$urandom_range(0, pool_size - 1)];
			send_op(op, k);
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty list, absent key, unused code, touch, fill, full
		send_op(CMD_VICTIM, 16'h0000);
		send_op(CMD_ERASE, 16'h1234);
		send_op(CMD_NOP, 16'hFFFF);
		send_op(CMD_INSERT, 16'h0000);
		send_op(CMD_INSERT, 16'hFFFF);
		send_op(CMD_INSERT, 16'h0000);
		send_op(CMD_ERASE, 16'hFFFF);
		for (int i = 1; i < LRU_CAPACITY; i++)
			send_op(CMD_INSERT, KEY_W'(i * 16'h1111));
		send_op(CMD_INSERT, 16'hABCD);
		send_op(CMD_INSERT, 16'h5555);
		send_op(CMD_VICTIM, 16'hFFFF);

		run_mixed(150, 12, 10);
		quiet = 1'b1;
		run_mixed(100, 24, 5);
		quiet = 1'b0;
		run_mixed(50, 20, 10);
		// receiver holds off while commands keep coming, so the input backs up
		pressure_req = 1'b1;
		run_mixed(100, 20, 10);
		run_mixed(100, 8, 20);

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_400_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
